// ----- src/uera_pkg.sv -----
`timescale 1ns / 1ps

package uera_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int PIN_COUNT       = 4;
  localparam int TICK_W          = 17;
  localparam int DIST_W          = 15;
  localparam int SUM_W           = 23;
  localparam int AVG_W           = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 17;

  localparam int TRIG_LOW_TICKS  = 2;
  localparam int TRIG_HIGH_TICKS = 10;
  localparam int MM_PER_CM       = 10;
  localparam int US_PER_CM       = 58;

  // floor(x/29) as (x * MM_RECIP) >> MM_SHIFT, exact for x below 2^20
  localparam int MM_SHIFT        = 25;
  localparam int MM_RECIP_W      = 21;
  localparam int MM_RECIP        = ((1 << MM_SHIFT) + US_PER_CM / 2 - 1) / (US_PER_CM / 2);

  localparam logic [AVG_W-1:0]  NUM_AVG_RST = AVG_W'(4);
  localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(120000);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_AVG = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(1);

  typedef struct packed {
    logic                 tick;
    logic                 start_req;
    logic [PIN_COUNT-1:0] echo;
    logic                 read_req;
    logic [1:0]           read_channel;
  } in_word_t;

  typedef struct packed {
    logic [PIN_COUNT-1:0] trigger;
    logic                 busy_res;
    logic                 available;
    logic [DIST_W-1:0]    distance;
  } out_word_t;

endpackage

// ----- src/uera_in_if.sv -----
`timescale 1ns / 1ps

interface uera_in_if import uera_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/uera_out_if.sv -----
`timescale 1ns / 1ps

interface uera_out_if import uera_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/uera_cfg_if.sv -----
`timescale 1ns / 1ps

interface uera_cfg_if import uera_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/uera_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module uera_div import uera_pkg::*; #(
  parameter int DW = SUM_W,
  parameter int VW = AVG_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [VW:0]   trial;
  logic          fits;
  logic [VW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= CW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DW-2:0], fits};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- src/ultrasonic_echo_ranger_avg.sv -----
`timescale 1ns / 1ps

// channel  | dir | handshake        | word
// ---------+-----+------------------+------------------------------------------
// in_i     | in  | valid/ready      | tick, start_req, echo, read_req, read_channel
// out_o    | out | valid/ready      | trigger, busy_res, available, distance
// cfg_i    | in  | valid/ready      | index (0 num_avg, 1 timeout_ticks), data
//
// an ordinary word is accepted, evaluated, and then its result is loaded into the output register;
// a word that ends a channel's echo adds a step: width*5 times a reciprocal of 29
// (width*10/58) in one registered multiply; the word that closes the last averaged
// round adds one sum/count division per channel on the shared divider
// (start, 23 quotient bits, hand-off)
// reset clears the sequencer, sums, stored distances and the registers to their
// defaults; in_i.ready stays low while a word is in work or its result cannot be loaded
module ultrasonic_echo_ranger_avg import uera_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uera_in_if.sink    in_i,
  uera_out_if.source out_o,
  uera_cfg_if.sink   cfg_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_END,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MM,
    ST_AVG,
    ST_EMIT
  } state_e;

  // configuration registers
  logic [AVG_W-1:0]  num_avg_q;
  logic [TICK_W-1:0] timeout_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_avg_q <= NUM_AVG_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_NUM_AVG: num_avg_q <= cfg_i.data[AVG_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_i.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath state
  state_e            st_q;
  phase_e            phase_q;
  logic [CH_W-1:0]   ch_q;
  logic [TICK_W-1:0] elapsed_q;
  logic [TICK_W-1:0] pulse_q;
  logic [DIST_W-1:0] stored_q [CHANNELS];
  logic [SUM_W-1:0]  sums_q [CHANNELS];
  logic [AVG_W-1:0]  rc_q;
  logic              avail_q;
  in_word_t          item_q;
  logic [CH_W-1:0]   fin_ch_q;
  logic              fin_last_q;
  logic [SUM_W-1:0]  mm_dvd_q;
  logic [CH_W-1:0]   avg_idx_q;
  logic              div_start_q;
  logic              out_valid_q;
  out_word_t         out_q;

  // divider hookup, sum/count per channel
  logic [SUM_W-1:0]  div_dvd;
  logic [AVG_W-1:0]  div_dvs;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;

  assign div_dvd = sums_q[avg_idx_q];
  assign div_dvs = rc_q;

  uera_div #(
    .DW(SUM_W),
    .VW(AVG_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // one step of the echo sequencer for the held word
  logic [TICK_W-1:0] lim;
  logic [TICK_W-1:0] e_sat;
  logic              to_hit;
  logic              level;
  logic              last_ch;
  phase_e            phase_d;
  logic [CH_W-1:0]   ch_d;
  logic [TICK_W-1:0] elapsed_d;
  logic [TICK_W-1:0] pulse_d;
  logic              fin_d;
  logic [TICK_W-1:0] fin_w_d;

  always_comb begin
    lim     = (timeout_q == '0) ? TICK_W'(1) : timeout_q;
    e_sat   = (elapsed_q != '1) ? elapsed_q + TICK_W'(1) : elapsed_q;
    to_hit  = e_sat >= lim;
    last_ch = !(32'(ch_q) + 1 < CHANNELS);
    level   = 1'b0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      if (i < CHANNELS && ch_q == CH_W'(i)) level = item_q.echo[i];
    end

    phase_d   = phase_q;
    ch_d      = ch_q;
    elapsed_d = elapsed_q;
    pulse_d   = pulse_q;
    fin_d     = 1'b0;
    fin_w_d   = '0;

    if (phase_q == PH_IDLE) begin
      if (item_q.start_req) begin
        phase_d   = PH_TRIG_LOW;
        ch_d      = '0;
        elapsed_d = '0;
        pulse_d   = '0;
      end
    end else if (item_q.tick) begin
      case (phase_q)
        PH_TRIG_LOW: begin
          if (32'(e_sat) >= TRIG_LOW_TICKS) begin
            phase_d   = PH_TRIG_HIGH;
            elapsed_d = '0;
          end else begin
            elapsed_d = e_sat;
          end
        end
        PH_TRIG_HIGH: begin
          if (32'(e_sat) >= TRIG_HIGH_TICKS) begin
            phase_d   = PH_WAIT_END;
            elapsed_d = '0;
          end else begin
            elapsed_d = e_sat;
          end
        end
        PH_WAIT_END: begin
          elapsed_d = e_sat;
          if (!level) phase_d = PH_WAIT_RISE;
          else if (to_hit) fin_d = 1'b1;
        end
        PH_WAIT_RISE: begin
          elapsed_d = e_sat;
          if (level) begin
            phase_d = PH_MEASURE;
            pulse_d = TICK_W'(1);
          end
          if (to_hit) fin_d = 1'b1;
        end
        PH_MEASURE: begin
          elapsed_d = e_sat;
          if (!level) begin
            fin_d   = 1'b1;
            fin_w_d = pulse_q;
          end else begin
            if (pulse_q != '1) pulse_d = pulse_q + TICK_W'(1);
            if (to_hit) fin_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // channel done: clear counters and move on to the next channel or to idle
    if (fin_d) begin
      elapsed_d = '0;
      pulse_d   = '0;
      if (last_ch) begin
        ch_d    = '0;
        phase_d = PH_IDLE;
      end else begin
        ch_d    = ch_q + CH_W'(1);
        phase_d = PH_TRIG_LOW;
      end
    end
  end

  // millimetres by reciprocal multiply, then round bookkeeping
  logic [AVG_W-1:0]              need;
  logic [AVG_W-1:0]              rc_inc;
  logic [SUM_W+MM_RECIP_W-1:0]   mm_prod;
  logic [DIST_W-1:0]             mm;

  assign need    = (num_avg_q == '0) ? AVG_W'(1) : num_avg_q;
  assign rc_inc  = rc_q + AVG_W'(1);
  assign mm_prod = mm_dvd_q * MM_RECIP_W'(MM_RECIP);
  assign mm      = mm_prod[MM_SHIFT +: DIST_W];

  // result word from the updated state
  out_word_t emit_word;

  always_comb begin
    emit_word = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      if (i < CHANNELS) begin
        emit_word.trigger[i] = (phase_q == PH_TRIG_HIGH) && (ch_q == CH_W'(i));
      end
    end
    emit_word.busy_res  = (phase_q != PH_IDLE);
    emit_word.available = avail_q && !item_q.read_req;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(item_q.read_channel) == i) emit_word.distance = stored_q[i];
    end
  end

  assign in_i.ready  = (st_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_IDLE;
      ch_q        <= '0;
      elapsed_q   <= '0;
      pulse_q     <= '0;
      rc_q        <= '0;
      avail_q     <= 1'b0;
      item_q      <= '0;
      fin_ch_q    <= '0;
      fin_last_q  <= 1'b0;
      mm_dvd_q    <= '0;
      avg_idx_q   <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        stored_q[i] <= '0;
        sums_q[i]   <= '0;
      end
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      case (st_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            item_q <= in_i.data;
            st_q   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          phase_q   <= phase_d;
          ch_q      <= ch_d;
          elapsed_q <= elapsed_d;
          pulse_q   <= pulse_d;
          if (fin_d) begin
            fin_ch_q   <= ch_q;
            fin_last_q <= last_ch;
            // width*5 as two shifted copies, the 2 of 10/58 cancels
            mm_dvd_q   <= (SUM_W'(fin_w_d) << 2) + SUM_W'(fin_w_d);
            st_q       <= ST_MM;
          end else begin
            st_q <= ST_EMIT;
          end
        end
        ST_MM: begin
          stored_q[fin_ch_q] <= mm;
          sums_q[fin_ch_q]   <= sums_q[fin_ch_q] + SUM_W'(mm);
          if (fin_last_q) begin
            rc_q <= rc_inc;
            if (rc_inc >= need) begin
              avg_idx_q   <= '0;
              div_start_q <= 1'b1;
              st_q        <= ST_AVG;
            end else begin
              st_q <= ST_EMIT;
            end
          end else begin
            st_q <= ST_EMIT;
          end
        end
        ST_AVG: begin
          if (div_done) begin
            stored_q[avg_idx_q] <= div_quot[DIST_W-1:0];
            sums_q[avg_idx_q]   <= '0;
            if (avg_idx_q == CH_W'(CHANNELS - 1)) begin
              avail_q <= 1'b1;
              rc_q    <= '0;
              st_q    <= ST_EMIT;
            end else begin
              avg_idx_q   <= avg_idx_q + CH_W'(1);
              div_start_q <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_q       <= emit_word;
            out_valid_q <= 1'b1;
            if (item_q.read_req) avail_q <= 1'b0;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule
